/* hdl/dsf_pkg.sv */
// Shared types, constants and helper functions for the diagnostic session engine.
package dsf_pkg;

    // Service and request codes
    localparam logic [7:0]  SVC_SESSION  = 8'h10;
    localparam logic [7:0]  SVC_SECURITY = 8'h27;
    localparam logic        REQ_TICK     = 1'b1;
    localparam logic [7:0]  MIN_REQ_LEN  = 8'd2;

    // Session numbers with special rules
    localparam logic [2:0]  SESS_DEFAULT = 3'd1;
    localparam logic [2:0]  SESS_PROG    = 3'd2;
    localparam logic [2:0]  SESS_FACTORY = 3'd4;
    localparam logic [7:0]  SESS_MAX     = 8'd4;

    // Seed generation and retry limits
    localparam logic [31:0] SEED_MULT    = 32'd16807;
    localparam logic [31:0] SEED_MOD     = 32'h7FFF_FFFF;
    localparam logic [3:0]  RETRY_MAX    = 4'd15;

    // Register map: index is paddr[3:2]
    localparam int          PADDR_W      = 4;
    localparam logic [1:0]  REG_TIMEOUT  = 2'd0;
    localparam logic [1:0]  REG_RETRY    = 2'd1;
    localparam logic [1:0]  REG_KEY_XOR  = 2'd2;
    localparam logic [1:0]  REG_KEY_ADD  = 2'd3;

    // Register reset values
    localparam logic [31:0] RST_TIMEOUT  = 32'd5000;
    localparam logic [3:0]  RST_RETRY    = 4'd3;
    localparam logic [31:0] RST_KEY_XOR  = 32'h7583_6AC4;
    localparam logic [31:0] RST_KEY_ADD  = 32'h1234_ABCD;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  service_id;
        logic [7:0]  sub_function;
        logic [31:0] key_value;
        logic [7:0]  request_length;
        logic [31:0] now_time;
        logic        factory_ok;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  session_now;
        logic        unlocked;
        logic [31:0] seed_out;
    } rsp_t;

    typedef struct packed {
        logic [31:0] session_timeout;
        logic [3:0]  retry_limit;
        logic [31:0] key_xor;
        logic [31:0] key_add;
    } cfg_t;

    // Expected key: rotate-left-13 of seed ^ xor, plus add
    function automatic logic [31:0] expected_key(input logic [31:0] seed,
                                                 input logic [31:0] kx,
                                                 input logic [31:0] ka);
        logic [31:0] v;
        v = seed ^ kx;
        return {v[18:0], v[31:19]} + ka;
    endfunction

    // Reduce a 32-bit product modulo 2^31-1, zero maps to one
    function automatic logic [31:0] reduce_seed(input logic [31:0] prod);
        logic [31:0] s;
        logic [31:0] r;
        s = {1'b0, prod[30:0]} + {31'd0, prod[31]};
        r = (s >= SEED_MOD) ? (s - SEED_MOD) : s;
        return (r == 32'd0) ? 32'd1 : r;
    endfunction

endpackage

/* hdl/dsf_cfg_regs.sv */
// APB-style configuration register file for the diagnostic session engine.
module dsf_cfg_regs
    import dsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.session_timeout <= RST_TIMEOUT;
            cfg_reg.retry_limit     <= RST_RETRY;
            cfg_reg.key_xor         <= RST_KEY_XOR;
            cfg_reg.key_add         <= RST_KEY_ADD;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_TIMEOUT: cfg_reg.session_timeout <= pwdata;
                REG_RETRY:   cfg_reg.retry_limit     <= pwdata[3:0];
                REG_KEY_XOR: cfg_reg.key_xor         <= pwdata;
                REG_KEY_ADD: cfg_reg.key_add         <= pwdata;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_TIMEOUT: prdata = cfg_reg.session_timeout;
            REG_RETRY:   prdata = {28'd0, cfg_reg.retry_limit};
            REG_KEY_XOR: prdata = cfg_reg.key_xor;
            REG_KEY_ADD: prdata = cfg_reg.key_add;
        endcase
    end

endmodule

/* hdl/diag_session_security_fsm.sv */
// Stages: input register, result register.
// Throughput: one item per cycle unless a held result stalls (rsp_valid high, rsp_ready low);
// the session and security state updates in the same cycle that the result register loads, and
// the seed multiply sits before the input register.
// Reset: rst_n clears both stages, returns to session 1, locked, no retries, no seed pending,
// seed 0, and loads the configuration register defaults.
module diag_session_security_fsm
    import dsf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t        cfg;

    // Input stage
    logic        s1_valid_reg;
    req_t        s1_req_reg;
    logic [31:0] s1_prod_reg;
    logic        s1_advance;

    // Engine state
    logic [2:0]  session_reg, session_next;
    logic [31:0] start_reg, start_next;
    logic        locked_reg, locked_next;
    logic [3:0]  retry_reg, retry_next;
    logic        awaiting_reg, awaiting_next;
    logic [31:0] seed_reg, seed_next;
    logic        acc;

    // Result stage
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    dsf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_advance;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Capture the item and its seed product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg  <= req;
            s1_prod_reg <= req.now_time * SEED_MULT;
        end
    end

    // Compute the next state and the acceptance flag
    always_comb
    begin
        session_next  = session_reg;
        start_next    = start_reg;
        locked_next   = locked_reg;
        retry_next    = retry_reg;
        awaiting_next = awaiting_reg;
        seed_next     = seed_reg;
        acc           = 1'b1;

        priority if (s1_req_reg.req_type == REQ_TICK)
        begin
            // Drop back to the default session on timeout
            if ((s1_req_reg.now_time - start_reg) >= cfg.session_timeout &&
                session_reg != SESS_DEFAULT)
            begin
                session_next  = SESS_DEFAULT;
                locked_next   = 1'b1;
                awaiting_next = 1'b0;
            end
        end
        else if (s1_req_reg.request_length < MIN_REQ_LEN)
        begin
            acc = 1'b0;
        end
        else if (s1_req_reg.service_id == SVC_SESSION)
        begin
            priority if (s1_req_reg.sub_function > SESS_MAX)
            begin
                acc = 1'b0;
            end
            else if (s1_req_reg.sub_function[2:0] == session_reg)
            begin
                start_next = s1_req_reg.now_time;
            end
            else if (s1_req_reg.sub_function[2:0] == SESS_PROG && locked_reg)
            begin
                acc = 1'b0;
            end
            else if (s1_req_reg.sub_function[2:0] == SESS_FACTORY &&
                     !s1_req_reg.factory_ok)
            begin
                acc = 1'b0;
            end
            else
            begin
                // Switch session, relock on entering the default session
                if (s1_req_reg.sub_function[2:0] == SESS_DEFAULT)
                begin
                    locked_next = 1'b1;
                end
                session_next = s1_req_reg.sub_function[2:0];
                start_next   = s1_req_reg.now_time;
            end
        end
        else if (s1_req_reg.service_id == SVC_SECURITY)
        begin
            if (s1_req_reg.sub_function[0])
            begin
                // Seed request: refuse and relock once retries are used up
                if (retry_reg >= cfg.retry_limit)
                begin
                    locked_next = 1'b1;
                    acc         = 1'b0;
                end
                else
                begin
                    seed_next     = reduce_seed(s1_prod_reg);
                    awaiting_next = 1'b1;
                end
            end
            else if (!awaiting_reg)
            begin
                acc = 1'b0;
            end
            else
            begin
                // Key check
                if (s1_req_reg.key_value == expected_key(seed_reg, cfg.key_xor, cfg.key_add))
                begin
                    locked_next = 1'b0;
                    retry_next  = '0;
                end
                else if (retry_reg < RETRY_MAX)
                begin
                    retry_next = retry_reg + 4'd1;
                end
                awaiting_next = 1'b0;
                acc           = !locked_next;
            end
        end
        else
        begin
            // Accept any other service with no change
            acc = 1'b1;
        end
    end

    // Update state and result when the item advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= SESS_DEFAULT;
            start_reg     <= '0;
            locked_reg    <= 1'b1;
            retry_reg     <= '0;
            awaiting_reg  <= 1'b0;
            seed_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                session_reg  <= session_next;
                start_reg    <= start_next;
                locked_reg   <= locked_next;
                retry_reg    <= retry_next;
                awaiting_reg <= awaiting_next;
                seed_reg     <= seed_next;
            end
            if (!rsp_valid_reg || rsp_ready)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            rsp_reg.accepted    <= acc;
            rsp_reg.session_now <= session_next;
            rsp_reg.unlocked    <= !locked_next;
            rsp_reg.seed_out    <= seed_next;
        end
    end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the diagnostic session and security-access engine.
module tb_top;
    import dsf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic        REQ_DIAG    = 1'b0;
    localparam logic [7:0]  SVC_OTHER   = 8'h3E;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_t               rsp;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predicted engine state and configuration
    cfg_t        m_cfg;
    logic [2:0]  m_session;
    logic [31:0] m_start;
    logic        m_locked;
    logic [3:0]  m_retries;
    logic        m_awaiting;
    logic [31:0] m_seed;

    rsp_t        due_status_q[$];
    rsp_t        oldest_due;
    int          fail_count;
    int unsigned cycle_count;
    int          stall_left;
    bit          gaps_on;
    logic [31:0] time_now;

    diag_session_security_fsm u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (!gaps_on)
        begin
            stall_left = 0;
            rsp_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_status_q.size() == 0)
            begin
                $error("result item with no prediction pending");
                fail_count++;
            end
            else
            begin
                oldest_due = due_status_q.pop_front();
                check_field("accepted", {31'd0, oldest_due.accepted}, {31'd0, rsp.accepted});
                check_field("session_now", {29'd0, oldest_due.session_now},
                            {29'd0, rsp.session_now});
                check_field("unlocked", {31'd0, oldest_due.unlocked}, {31'd0, rsp.unlocked});
                check_field("seed_out", oldest_due.seed_out, rsp.seed_out);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    function automatic logic [31:0] seed_from_time(input logic [31:0] t);
        logic [31:0] prod;
        logic [31:0] s;
        prod = t * SEED_MULT;
        s = prod % SEED_MOD;
        return (s == 32'd0) ? 32'd1 : s;
    endfunction

    function automatic logic [31:0] session_key(input logic [31:0] seed);
        logic [31:0] v;
        v = seed ^ m_cfg.key_xor;
        return ((v << 13) | (v >> 19)) + m_cfg.key_add;
    endfunction

    // Apply one item to the predicted state and return the status it yields
    function automatic rsp_t advance_session(input req_t r);
        rsp_t        res;
        logic [31:0] elapsed;
        res.accepted = 1'b1;
        if (r.req_type == REQ_TICK)
        begin
            elapsed = r.now_time - m_start;
            if (elapsed >= m_cfg.session_timeout && m_session != SESS_DEFAULT)
            begin
                m_session  = SESS_DEFAULT;
                m_locked   = 1'b1;
                m_awaiting = 1'b0;
            end
        end
        else if (r.request_length < MIN_REQ_LEN)
        begin
            res.accepted = 1'b0;
        end
        else if (r.service_id == SVC_SESSION)
        begin
            if (r.sub_function > SESS_MAX)
                res.accepted = 1'b0;
            else if (r.sub_function[2:0] == m_session)
                m_start = r.now_time;
            else if (r.sub_function[2:0] == SESS_DEFAULT)
            begin
                m_locked  = 1'b1;
                m_session = SESS_DEFAULT;
                m_start   = r.now_time;
            end
            else if (r.sub_function[2:0] == SESS_PROG && m_locked)
                res.accepted = 1'b0;
            else if (r.sub_function[2:0] == SESS_FACTORY && !r.factory_ok)
                res.accepted = 1'b0;
            else
            begin
                m_session = r.sub_function[2:0];
                m_start   = r.now_time;
            end
        end
        else if (r.service_id == SVC_SECURITY)
        begin
            if (r.sub_function[0])
            begin
                // Seed request: refused and relocked once retries hit the limit
                if (m_retries >= m_cfg.retry_limit)
                begin
                    m_locked     = 1'b1;
                    res.accepted = 1'b0;
                end
                else
                begin
                    m_seed     = seed_from_time(r.now_time);
                    m_awaiting = 1'b1;
                end
            end
            else if (!m_awaiting)
            begin
                res.accepted = 1'b0;
            end
            else
            begin
                if (r.key_value == session_key(m_seed))
                begin
                    m_locked  = 1'b0;
                    m_retries = 4'd0;
                end
                else if (m_retries < RETRY_MAX)
                begin
                    m_retries = m_retries + 4'd1;
                end
                m_awaiting   = 1'b0;
                res.accepted = !m_locked;
            end
        end
        res.session_now = m_session;
        res.unlocked    = !m_locked;
        res.seed_out    = m_seed;
        return res;
    endfunction

    function automatic req_t make_req(input logic t, input logic [7:0] svc,
                                      input logic [7:0] sub, input logic [31:0] key,
                                      input logic [7:0] len, input logic [31:0] now,
                                      input logic fac);
        req_t r;
        r.req_type       = t;
        r.service_id     = svc;
        r.sub_function   = sub;
        r.key_value      = key;
        r.request_length = len;
        r.now_time       = now;
        r.factory_ok     = fac;
        return r;
    endfunction

    // Send one item and record its predicted status on acceptance
    task automatic send_item(input req_t item);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        due_status_q.push_back(advance_session(item));
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic drain_results();
        req_valid <= 1'b0;
        while (due_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_TIMEOUT: m_cfg.session_timeout = value;
            REG_RETRY:   m_cfg.retry_limit     = value[3:0];
            REG_KEY_XOR: m_cfg.key_xor         = value;
            REG_KEY_ADD: m_cfg.key_add         = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] timeout, input logic [3:0] retries,
                              input logic [31:0] kx, input logic [31:0] ka);
        drain_results();
        write_reg(REG_TIMEOUT, timeout);
        write_reg(REG_RETRY, {28'd0, retries});
        write_reg(REG_KEY_XOR, kx);
        write_reg(REG_KEY_ADD, ka);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Session rules and the key flow under reset configuration
    task automatic test_directed_rules();
        send_item(make_req(REQ_TICK, 8'h00, 8'h00, 32'h0, 8'd0, 32'd0, 1'b0));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'd3, 32'hFFFF_FFFF, 8'd0, 32'd10, 1'b1));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'd3, 32'h0, 8'd1, 32'd10, 1'b1));
        send_item(make_req(REQ_DIAG, SVC_OTHER, 8'hFF, 32'h0, 8'd255, 32'd20, 1'b0));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'd5, 32'h0, 8'd2, 32'd30, 1'b1));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'hFF, 32'h0, 8'd2, 32'd30, 1'b1));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'(SESS_PROG), 32'h0, 8'd2, 32'd40, 1'b1));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'(SESS_FACTORY), 32'h0, 8'd2, 32'd50,
                           1'b0));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'(SESS_FACTORY), 32'h0, 8'd2, 32'd60,
                           1'b1));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'(SESS_FACTORY), 32'h0, 8'd2, 32'd100,
                           1'b0));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'd0, 32'h0, 8'd2, 32'd110, 1'b0));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'(SESS_DEFAULT), 32'h0, 8'd2, 32'd120,
                           1'b0));
        // Key with no seed pending
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'd2, 32'h0, 8'd6, 32'd130, 1'b0));
        // Zero product maps to seed one, then the correct key unlocks
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'd1, 32'h0, 8'd2, 32'd0, 1'b0));
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'd2, session_key(m_seed), 8'd2,
                           32'd140, 1'b0));
        // Wrong key while already unlocked stays unlocked and accepted
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'h03, 32'h0, 8'd2, 32'hFFFF_FFFF, 1'b0));
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'hFE, ~session_key(m_seed), 8'd255,
                           32'd150, 1'b1));
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'(SESS_PROG), 32'h0, 8'd2, 32'hFFFF_FF00,
                           1'b0));
        // Tick one unit short of the timeout, then exactly at it across the wrap
        send_item(make_req(REQ_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'd255,
                           m_start + RST_TIMEOUT - 32'd1, 1'b1));
        send_item(make_req(REQ_TICK, 8'h00, 8'h00, 32'h0, 8'd0, m_start + RST_TIMEOUT, 1'b0));
    endtask

    // Seed refusal once the retry limit is reached, including a limit of zero
    task automatic test_retry_limits();
        set_config(RST_TIMEOUT, 4'd1, 32'h0, 32'h0);
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'h01, 32'h0, 8'd2, 32'h0001_2345, 1'b0));
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'h80, ~session_key(m_seed), 8'd2,
                           32'd10, 1'b0));
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'hFF, 32'h0, 8'd2, 32'd20, 1'b0));
        set_config(RST_TIMEOUT, 4'd0, RST_KEY_XOR, RST_KEY_ADD);
        send_item(make_req(REQ_DIAG, SVC_SECURITY, 8'h01, 32'h0, 8'd2, 32'd30, 1'b0));
    endtask

    // Zero timeout and the largest timeout with wrapping elapsed time
    task automatic test_timeout_edges();
        set_config(32'd0, RST_RETRY, RST_KEY_XOR, RST_KEY_ADD);
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'd3, 32'h0, 8'd2, 32'd500, 1'b0));
        send_item(make_req(REQ_TICK, 8'h00, 8'h00, 32'h0, 8'd0, 32'd500, 1'b0));
        set_config(32'hFFFF_FFFF, RST_RETRY, RST_KEY_XOR, RST_KEY_ADD);
        send_item(make_req(REQ_DIAG, SVC_SESSION, 8'd3, 32'h0, 8'd2, 32'd10, 1'b0));
        send_item(make_req(REQ_TICK, 8'h00, 8'h00, 32'h0, 8'd0, 32'd8, 1'b0));
        send_item(make_req(REQ_TICK, 8'h00, 8'h00, 32'h0, 8'd0, 32'd9, 1'b0));
    endtask

    // Mostly well-formed session and seed/key traffic, with noise mixed in
    task automatic test_random_traffic(input int count, input bit idle_ok);
        req_t item;
        int   kind;
        for (int i = 0; i < count; i++)
        begin
            gaps_on = idle_ok && ((i / 40) % 4 != 3);
            if ($urandom_range(0, 49) == 0)
                time_now = $urandom;
            else
                time_now = time_now + $urandom_range(0, 400);
            item.req_type       = REQ_DIAG;
            item.service_id     = 8'($urandom);
            item.sub_function   = 8'($urandom);
            item.key_value      = $urandom;
            item.request_length = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, 255))
                                                              : 8'($urandom_range(2, 6));
            item.now_time       = time_now;
            item.factory_ok     = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                item.req_type = REQ_TICK;
            end
            else if (kind < 40)
            begin
                item.service_id = SVC_SESSION;
                if ($urandom_range(0, 9) != 0)
                    item.sub_function = 8'($urandom_range(0, 5));
            end
            else if (kind < 60)
            begin
                item.service_id      = SVC_SECURITY;
                item.sub_function[0] = 1'b1;
            end
            else if (kind < 85)
            begin
                item.service_id      = SVC_SECURITY;
                item.sub_function[0] = 1'b0;
                if (m_awaiting && $urandom_range(0, 9) < 7)
                    item.key_value = session_key(m_seed);
            end
            else if (kind >= 95)
            begin
                // Short request aimed at a real service
                item.request_length = 8'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 0)
                    item.service_id = SVC_SESSION;
                else
                    item.service_id = SVC_SECURITY;
            end
            send_item(item);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b1;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        gaps_on   = 1'b0;
        time_now  = 32'd0;
        fail_count = 0;
        m_cfg.session_timeout = RST_TIMEOUT;
        m_cfg.retry_limit     = RST_RETRY;
        m_cfg.key_xor         = RST_KEY_XOR;
        m_cfg.key_add         = RST_KEY_ADD;
        m_session  = SESS_DEFAULT;
        m_start    = 32'd0;
        m_locked   = 1'b1;
        m_retries  = 4'd0;
        m_awaiting = 1'b0;
        m_seed     = 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        gaps_on = 1'b1;
        test_directed_rules();
        test_retry_limits();
        test_timeout_edges();

        set_config(32'd1, 4'd1, 32'h0, 32'h0);
        test_random_traffic(160, 1'b1);
        set_config(32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_random_traffic(160, 1'b1);
        set_config(RST_TIMEOUT, RST_RETRY, RST_KEY_XOR, RST_KEY_ADD);
        test_random_traffic(160, 1'b1);
        set_config($urandom_range(200, 3000), 4'($urandom_range(0, 15)), $urandom, $urandom);
        test_random_traffic(160, 1'b1);
        // Last stretch runs with both sides streaming
        set_config($urandom_range(500, 6000), 4'($urandom_range(1, 15)), $urandom, $urandom);
        test_random_traffic(160, 1'b0);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* diag_session_security_fsm.f */
hdl/dsf_pkg.sv
hdl/dsf_cfg_regs.sv
hdl/diag_session_security_fsm.sv
tb/tb_top.sv
